[design/first_fit_chunk_allocator_assert.svh]
// assertion macros for the chunk allocator checker
// both sample on clk and are disabled while arst_n is low
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define FFCA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ffca_pkg.sv]
package ffca_pkg;

	localparam int IN_W     = 32;
	localparam int LIVE_W   = 6;
	localparam int PAD_W    = 16;
	localparam int ALOG_W   = 5;
	localparam int MSPLIT_W = 16;
	localparam int CFG_W    = 32;
	localparam int NEED_W   = 33;

	localparam logic [ALOG_W-1:0]   MAX_ALOG      = 5'd16;
	localparam logic [CFG_W-1:0]    POOL_SIZE_RST = 32'd1048576;
	localparam logic [MSPLIT_W-1:0] MIN_SPLIT_RST = 16'd64;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		REG_POOL_SIZE = 1'b0,
		REG_MIN_SPLIT = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_RD_IDX,
		CMD_RD_PTR,
		CMD_NEXT,
		CMD_A_EVAL,
		CMD_A_SPLIT,
		CMD_U_RD,
		CMD_U_WR,
		CMD_A_INS,
		CMD_A_TAKE,
		CMD_F_EVAL,
		CMD_F_FWD,
		CMD_F_BSET,
		CMD_F_BWD,
		CMD_F_WR,
		CMD_D_WR,
		CMD_F_END
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    fin;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic usable;
		logic split;
		logic full;
		logic match;
		logic ent_free;
		logic ptr_last;
		logic ptr_zero;
		logic lo_zero;
		logic ptr_above;
		logic ptr_in;
	} dp_sts_t;

endpackage

[design/ffca_ram.sv]
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/ffca_ctrl.sv]
module ffca_ctrl import ffca_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    op,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_A_RD,
		S_A_EV,
		S_A_SPL,
		S_U_RD,
		S_U_WR,
		S_A_TAKE,
		S_F_RD,
		S_F_EV,
		S_F_FRD,
		S_F_FEV,
		S_F_BSET,
		S_F_BRD,
		S_F_BEV,
		S_F_WR,
		S_D_RD,
		S_D_WR
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d  = state_q;
		cmd.op   = CMD_NONE;
		cmd.fin  = 1'b0;
		cmd.code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = CMD_LOAD;
					state_d = (op == OP_FREE) ? S_F_RD : S_A_RD;
				end
			end
			// allocate: first-fit scan
			S_A_RD: begin
				cmd.op  = CMD_RD_IDX;
				state_d = S_A_EV;
			end
			S_A_EV: begin
				if (sts.usable) begin
					cmd.op  = CMD_A_EVAL;
					state_d = S_A_SPL;
				end else if (sts.idx_last) begin
					cmd.fin  = 1'b1;
					cmd.code = ST_NOFIT;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = CMD_NEXT;
					state_d = S_A_RD;
				end
			end
			S_A_SPL: begin
				cmd.op = CMD_A_SPLIT;
				if (sts.split && sts.full) begin
					cmd.fin  = 1'b1;
					cmd.code = ST_FULL;
					state_d  = S_IDLE;
				end else if (sts.split) begin
					state_d = S_U_RD;
				end else begin
					state_d = S_A_TAKE;
				end
			end
			// open a hole after the taken entry
			S_U_RD: begin
				if (sts.ptr_above) begin
					cmd.op  = CMD_U_RD;
					state_d = S_U_WR;
				end else begin
					cmd.op  = CMD_A_INS;
					state_d = S_A_TAKE;
				end
			end
			S_U_WR: begin
				cmd.op  = CMD_U_WR;
				state_d = S_U_RD;
			end
			S_A_TAKE: begin
				cmd.op   = CMD_A_TAKE;
				cmd.fin  = 1'b1;
				cmd.code = ST_OK;
				state_d  = S_IDLE;
			end
			// free: look up the handle
			S_F_RD: begin
				cmd.op  = CMD_RD_IDX;
				state_d = S_F_EV;
			end
			S_F_EV: begin
				if (sts.match) begin
					cmd.op  = CMD_F_EVAL;
					state_d = sts.idx_last ? S_F_BSET : S_F_FRD;
				end else if (sts.idx_last) begin
					cmd.fin  = 1'b1;
					cmd.code = ST_NOTFOUND;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = CMD_NEXT;
					state_d = S_F_RD;
				end
			end
			// absorb free neighbours after, then before
			S_F_FRD: begin
				cmd.op  = CMD_RD_PTR;
				state_d = S_F_FEV;
			end
			S_F_FEV: begin
				if (sts.ent_free) begin
					cmd.op  = CMD_F_FWD;
					state_d = sts.ptr_last ? S_F_BSET : S_F_FRD;
				end else begin
					state_d = S_F_BSET;
				end
			end
			S_F_BSET: begin
				if (sts.lo_zero) begin
					state_d = S_F_WR;
				end else begin
					cmd.op  = CMD_F_BSET;
					state_d = S_F_BRD;
				end
			end
			S_F_BRD: begin
				cmd.op  = CMD_RD_PTR;
				state_d = S_F_BEV;
			end
			S_F_BEV: begin
				if (sts.ent_free) begin
					cmd.op  = CMD_F_BWD;
					state_d = sts.ptr_zero ? S_F_WR : S_F_BRD;
				end else begin
					state_d = S_F_WR;
				end
			end
			S_F_WR: begin
				cmd.op  = CMD_F_WR;
				state_d = S_D_RD;
			end
			// close the gap left by merged entries
			S_D_RD: begin
				if (sts.ptr_in) begin
					cmd.op  = CMD_RD_PTR;
					state_d = S_D_WR;
				end else begin
					cmd.op   = CMD_F_END;
					cmd.fin  = 1'b1;
					cmd.code = ST_OK;
					state_d  = S_IDLE;
				end
			end
			S_D_WR: begin
				cmd.op  = CMD_D_WR;
				state_d = S_D_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.fin;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

[design/ffca_dp.sv]
module ffca_dp import ffca_pkg::*; #(
	parameter int MAX_CHUNKS  = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              op,
	input  logic [IN_W-1:0]   req_size,
	input  logic [ALOG_W-1:0] align_log2,
	input  logic [IN_W-1:0]   free_handle,
	input  logic              cfg_wen,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output status_t           res_status,
	output logic [IN_W-1:0]   res_handle,
	output logic [IN_W-1:0]   res_offset,
	output logic [IN_W-1:0]   res_size,
	output logic [LIVE_W-1:0] res_live
);

	localparam int IW = $clog2(MAX_CHUNKS);
	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam int OB = OFFSET_BITS;
	localparam int CB = (OB > NEED_W) ? OB : NEED_W;
	localparam int WB = (OB > IN_W) ? OB : IN_W;
	localparam int EW = 1 + 2 * OB;

	typedef struct packed {
		logic          used;
		logic [OB-1:0] size;
		logic [OB-1:0] start;
	} entry_t;

	// configuration
	logic [CFG_W-1:0]    pool_q;
	logic [MSPLIT_W-1:0] mins_q;
	logic                pool_wr;

	// table and bookkeeping
	logic          fresh_q, rd0_q;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, ptr_q, lo_q, hi_q, gap_q;

	// transaction operands and scan results
	op_t               op_q;
	logic [IN_W-1:0]   req_q, handle_q;
	logic [ALOG_W-1:0] alog_q;
	logic [OB-1:0]     cur_start_q, cur_size_q, left_q, sum_q;
	logic [NEED_W-1:0] need_q;
	logic [PAD_W-1:0]  pad_q;
	logic              split_q;

	// results
	status_t           res_status_q;
	logic [IN_W-1:0]   res_handle_q, res_offset_q, res_size_q;
	logic [LIVE_W-1:0] res_live_q;

	// ram
	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	// combinational
	entry_t            ent;
	logic [WB-1:0]     pool_ext;
	logic [PAD_W-1:0]  align_mask, pad_c;
	logic [NEED_W-1:0] need_c;
	logic [CB-1:0]     left_ext, ins_ext, need_ext, dsize_ext;
	logic [OB-1:0]     left_c, ins_start, take_size;
	logic              split_c;
	logic [CW-1:0]     idx_p1, ptr_p1, ptr_m1, del_addr;

	assign pool_wr  = cfg_wen && (cfg_index == REG_POOL_SIZE);
	assign pool_ext = WB'(pool_q);

	// entry 0 reads as the whole pool until it is first written
	always_comb begin
		ent = entry_t'(ram_rdata);
		if (fresh_q && rd0_q) begin
			ent.used  = 1'b0;
			ent.size  = pool_ext[OB-1:0];
			ent.start = '0;
		end
	end

	assign idx_p1   = idx_q + 1'b1;
	assign ptr_p1   = ptr_q + 1'b1;
	assign ptr_m1   = ptr_q - 1'b1;
	assign del_addr = ptr_q - gap_q;

	assign align_mask = ~({PAD_W{1'b1}} << alog_q);
	assign pad_c      = (PAD_W'(0) - ent.start[PAD_W-1:0]) & align_mask;
	assign need_c     = NEED_W'(req_q) + NEED_W'(pad_c);

	assign need_ext  = CB'(need_q);
	assign left_ext  = CB'(cur_size_q) - need_ext;
	assign left_c    = left_ext[OB-1:0];
	assign split_c   = left_c > OB'(mins_q);
	assign ins_ext   = CB'(cur_start_q) + need_ext;
	assign ins_start = ins_ext[OB-1:0];
	assign take_size = split_q ? need_ext[OB-1:0] : cur_size_q;
	assign dsize_ext = CB'(take_size) - CB'(pad_q);

	always_comb begin
		sts.idx_last  = idx_p1 >= count_q;
		sts.usable    = !ent.used && (CB'(ent.size) >= CB'(need_c));
		sts.split     = split_c;
		sts.full      = count_q == CW'(MAX_CHUNKS);
		sts.match     = WB'(ent.start) == WB'(handle_q);
		sts.ent_free  = !ent.used;
		sts.ptr_last  = ptr_p1 >= count_q;
		sts.ptr_zero  = ptr_q == '0;
		sts.lo_zero   = lo_q == '0;
		sts.ptr_above = ptr_q > idx_p1;
		sts.ptr_in    = ptr_q < count_q;
	end

	always_comb begin
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ent;
		case (cmd.op)
			CMD_RD_IDX: ram_raddr = idx_q[IW-1:0];
			CMD_RD_PTR: ram_raddr = ptr_q[IW-1:0];
			CMD_U_RD:   ram_raddr = ptr_m1[IW-1:0];
			CMD_U_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[IW-1:0];
			end
			CMD_A_INS: begin
				ram_we    = 1'b1;
				ram_waddr = idx_p1[IW-1:0];
				ram_wdata = {1'b0, left_q, ins_start};
			end
			CMD_A_TAKE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[IW-1:0];
				ram_wdata = {1'b1, take_size, cur_start_q};
			end
			CMD_F_WR: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q[IW-1:0];
				ram_wdata = {1'b0, sum_q, cur_start_q};
			end
			CMD_D_WR: begin
				ram_we    = 1'b1;
				ram_waddr = del_addr[IW-1:0];
			end
			default: ram_we = 1'b0;
		endcase
	end

	ffca_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_CHUNKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		count_d = count_q;
		if (cmd.op == CMD_A_TAKE && split_q) begin
			count_d = count_q + 1'b1;
		end else if (cmd.op == CMD_F_END) begin
			count_d = count_q - gap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= POOL_SIZE_RST;
			mins_q  <= MIN_SPLIT_RST;
			count_q <= CW'(1);
			fresh_q <= 1'b1;
			rd0_q   <= 1'b0;
		end else begin
			rd0_q <= (ram_raddr == '0);
			if (cfg_wen) begin
				case (cfg_index)
					REG_POOL_SIZE: pool_q <= cfg_wdata;
					REG_MIN_SPLIT: mins_q <= cfg_wdata[MSPLIT_W-1:0];
					default: ;
				endcase
			end
			if (pool_wr) begin
				count_q <= CW'(1);
				fresh_q <= 1'b1;
			end else begin
				count_q <= count_d;
				if (ram_we && ram_waddr == '0) begin
					fresh_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				op_q     <= op_t'(op);
				req_q    <= req_size;
				alog_q   <= (align_log2 > MAX_ALOG) ? MAX_ALOG : align_log2;
				handle_q <= free_handle;
				idx_q    <= '0;
			end
			CMD_NEXT: idx_q <= idx_p1;
			CMD_A_EVAL: begin
				cur_start_q <= ent.start;
				cur_size_q  <= ent.size;
				need_q      <= need_c;
				pad_q       <= pad_c;
			end
			CMD_A_SPLIT: begin
				left_q  <= left_c;
				split_q <= split_c;
				ptr_q   <= count_q;
			end
			CMD_U_WR: ptr_q <= ptr_m1;
			CMD_F_EVAL: begin
				cur_start_q <= ent.start;
				sum_q       <= ent.size;
				lo_q        <= idx_q;
				hi_q        <= idx_q;
				ptr_q       <= idx_p1;
			end
			CMD_F_FWD: begin
				sum_q <= sum_q + ent.size;
				hi_q  <= ptr_q;
				ptr_q <= ptr_p1;
			end
			CMD_F_BSET: ptr_q <= lo_q - 1'b1;
			CMD_F_BWD: begin
				sum_q       <= sum_q + ent.size;
				lo_q        <= ptr_q;
				cur_start_q <= ent.start;
				ptr_q       <= ptr_m1;
			end
			CMD_F_WR: begin
				ptr_q <= hi_q + 1'b1;
				gap_q <= hi_q - lo_q;
			end
			CMD_D_WR: ptr_q <= ptr_p1;
			default: ;
		endcase
	end

	// result capture on the last step of a transaction
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			res_status_q <= cmd.code;
			res_live_q   <= LIVE_W'(count_d);
			res_handle_q <= '0;
			res_offset_q <= '0;
			res_size_q   <= '0;
			if (cmd.code == ST_OK) begin
				if (op_q == OP_ALLOC) begin
					res_handle_q <= IN_W'(cur_start_q);
					res_offset_q <= IN_W'(WB'(cur_start_q) + WB'(pad_q));
					res_size_q   <= IN_W'(dsize_ext);
				end else begin
					res_handle_q <= handle_q;
				end
			end
		end
	end

	assign res_status = res_status_q;
	assign res_handle = res_handle_q;
	assign res_offset = res_offset_q;
	assign res_size   = res_size_q;
	assign res_live   = res_live_q;

endmodule

[design/first_fit_chunk_allocator.sv]
// allocate: scan entries first-fit, check the split, move entries up to open a hole, write back
// free: scan for the handle, absorb free neighbours after then before, write back, move entries down
// one transaction at a time, result strobe on done the cycle after the last step
// done is high for one cycle and cannot be stalled; busy is low again in that cycle
// reset: one free chunk of 1048576 bytes at offset 0, min_split 64, no clearing pass
module first_fit_chunk_allocator import ffca_pkg::*; #(
	parameter int MAX_CHUNKS  = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [IN_W-1:0]   req_size,
	input  logic [ALOG_W-1:0] align_log2,
	input  logic [IN_W-1:0]   free_handle,
	input  logic              cfg_wen,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output logic              done,
	output logic [1:0]        status,
	output logic [IN_W-1:0]   chunk_handle,
	output logic [IN_W-1:0]   data_offset,
	output logic [IN_W-1:0]   data_size,
	output logic [LIVE_W-1:0] live_chunks
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	status_t res_status;

	ffca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ffca_dp #(
		.MAX_CHUNKS  (MAX_CHUNKS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.req_size    (req_size),
		.align_log2  (align_log2),
		.free_handle (free_handle),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.res_status  (res_status),
		.res_handle  (chunk_handle),
		.res_offset  (data_offset),
		.res_size    (data_size),
		.res_live    (live_chunks)
	);

	assign status = res_status;

endmodule

[design/ffca_chk.sv]
`include "first_fit_chunk_allocator_assert.svh"

module ffca_chk import ffca_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input logic [1:0]      status,
	input logic [IN_W-1:0] chunk_handle,
	input logic [IN_W-1:0] data_offset,
	input logic [IN_W-1:0] data_size
);

	`FFCA_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
	`FFCA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not started")
	`FFCA_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`FFCA_ASSERT_SAME(a_busy_end, $fell(busy), done, "transaction ended without result")
	`FFCA_ASSERT_SAME(a_err_zero, done && status != ST_OK, chunk_handle == '0 && data_offset == '0 && data_size == '0, "error result carries data")

endmodule

bind first_fit_chunk_allocator ffca_chk u_ffca_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.chunk_handle (chunk_handle),
	.data_offset  (data_offset),
	.data_size    (data_size)
);

[sim/first_fit_chunk_allocator_test.sv]
`timescale 1ns / 100ps

module first_fit_chunk_allocator_test;
	import ffca_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int CHUNK_SLOTS     = 32;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 185;
	localparam int LATE_FROM       = PHASES * ITEMS_PER_PHASE - 150;

	typedef struct {
		bit          is_cfg;
		reg_idx_t    reg_sel;
		logic [31:0] reg_val;
		op_t         kind;
		logic [31:0] bytes;
		logic [4:0]  alog;
		logic [31:0] handle;
		int          gap;
	} pool_req_t;

	typedef struct {
		status_t           st;
		logic [31:0]       handle;
		logic [31:0]       offset;
		logic [31:0]       nbytes;
		logic [LIVE_W-1:0] live;
	} alloc_reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              op = 1'b0;
	logic [IN_W-1:0]   req_size = '0;
	logic [ALOG_W-1:0] align_log2 = '0;
	logic [IN_W-1:0]   free_handle = '0;
	logic              cfg_wen = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              done;
	logic [1:0]        status;
	logic [IN_W-1:0]   chunk_handle;
	logic [IN_W-1:0]   data_offset;
	logic [IN_W-1:0]   data_size;
	logic [LIVE_W-1:0] live_chunks;

	// chunk table as the allocator should hold it
	logic [31:0] chunk_start [CHUNK_SLOTS];
	logic [31:0] chunk_size [CHUNK_SLOTS];
	bit          chunk_used [CHUNK_SLOTS];
	int          entry_total;
	logic [31:0] pool_bytes;
	logic [15:0] split_min;

	pool_req_t    pending_requests[$];
	alloc_reply_t expected_replies[$];
	pool_req_t    cur_request;
	alloc_reply_t due;
	bit           tx_taken;
	bit           cfg_now;
	int           gap_left;
	int           idle_run;
	int           mismatches = 0;
	bit           quiet_mode = 1'b0;

	first_fit_chunk_allocator #(
		.MAX_CHUNKS(CHUNK_SLOTS),
		.OFFSET_BITS(32)
	) dut (.*);

	always #HALF_PERIOD clk = ~clk;

	function automatic void load_register(reg_idx_t r, logic [31:0] v);
		int k;
		if (r == REG_POOL_SIZE) begin
			pool_bytes = v;
			for (k = 0; k < CHUNK_SLOTS; k++) begin
				chunk_start[k] = '0;
				chunk_size[k] = '0;
				chunk_used[k] = 1'b0;
			end
			chunk_size[0] = v;
			entry_total = 1;
		end else begin
			split_min = v[15:0];
		end
	endfunction

	// folds entry k+1 into entry k when both are free
	function automatic bit join_next(int k);
		int m;
		if (k + 1 >= entry_total || chunk_used[k] || chunk_used[k + 1])
			return 1'b0;
		chunk_size[k] = chunk_size[k] + chunk_size[k + 1];
		for (m = k + 1; m + 1 < entry_total; m++) begin
			chunk_start[m] = chunk_start[m + 1];
			chunk_size[m] = chunk_size[m + 1];
			chunk_used[m] = chunk_used[m + 1];
		end
		entry_total--;
		return 1'b1;
	endfunction

	function automatic alloc_reply_t apply_request(pool_req_t rq);
		alloc_reply_t r;
		logic [4:0]  alog_eff;
		logic [31:0] mask;
		logic [31:0] pad;
		logic [31:0] left;
		logic [32:0] need;
		int          hit;
		int          k;
		r.st = ST_NOFIT;
		r.handle = '0;
		r.offset = '0;
		r.nbytes = '0;
		hit = -1;
		if (rq.kind == OP_ALLOC) begin
			alog_eff = (rq.alog > MAX_ALOG) ? MAX_ALOG : rq.alog;
			mask = (32'd1 << alog_eff) - 32'd1;
			for (k = 0; k < entry_total; k++) begin
				pad = (32'd0 - chunk_start[k]) & mask;
				need = {1'b0, pad} + {1'b0, rq.bytes};
				if (hit < 0 && !chunk_used[k] && {1'b0, chunk_size[k]} >= need)
					hit = k;
			end
			if (hit >= 0) begin
				pad = (32'd0 - chunk_start[hit]) & mask;
				need = {1'b0, pad} + {1'b0, rq.bytes};
				left = chunk_size[hit] - need[31:0];
				if (left > {16'd0, split_min} && entry_total >= CHUNK_SLOTS) begin
					r.st = ST_FULL;
				end else begin
					if (left > {16'd0, split_min}) begin
						for (k = entry_total; k > hit + 1; k--) begin
							chunk_start[k] = chunk_start[k - 1];
							chunk_size[k] = chunk_size[k - 1];
							chunk_used[k] = chunk_used[k - 1];
						end
						chunk_start[hit + 1] = chunk_start[hit] + need[31:0];
						chunk_size[hit + 1] = left;
						chunk_used[hit + 1] = 1'b0;
						entry_total++;
						chunk_size[hit] = need[31:0];
					end
					chunk_used[hit] = 1'b1;
					r.st = ST_OK;
					r.handle = chunk_start[hit];
					r.offset = chunk_start[hit] + pad;
					r.nbytes = chunk_size[hit] - pad;
				end
			end
		end else begin
			r.st = ST_NOTFOUND;
			for (k = 0; k < entry_total; k++)
				if (hit < 0 && chunk_start[k] == rq.handle)
					hit = k;
			if (hit >= 0) begin
				chunk_used[hit] = 1'b0;
				while (join_next(hit)) begin
				end
				while (hit > 0 && join_next(hit - 1))
					hit--;
				r.st = ST_OK;
				r.handle = rq.handle;
			end
		end
		r.live = LIVE_W'(entry_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_wen <= 1'b0;
			gap_left <= 0;
			idle_run <= 0;
		end else begin
			tx_taken = start && !busy;
			cfg_now = 1'b0;
			if (tx_taken)
				expected_replies.push_back(apply_request(cur_request));
			if (start && !tx_taken) begin
				start <= 1'b1;
			end else if (tx_taken && cur_request.gap != 0) begin
				start <= 1'b0;
				gap_left <= cur_request.gap;
			end else if (gap_left != 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() != 0 && !pending_requests[0].is_cfg) begin
				cur_request = pending_requests.pop_front();
				op <= cur_request.kind;
				req_size <= cur_request.bytes;
				align_log2 <= cur_request.alog;
				free_handle <= cur_request.handle;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
				// register writes only once the block has been quiet for a while
				if (pending_requests.size() != 0 && idle_run >= SETTLE_CYCLES && !tx_taken) begin
					cur_request = pending_requests.pop_front();
					cfg_now = 1'b1;
					cfg_index <= cur_request.reg_sel;
					cfg_wdata <= cur_request.reg_val;
					load_register(cur_request.reg_sel, cur_request.reg_val);
				end
			end
			cfg_wen <= cfg_now;
			if (!start && !busy && !cfg_wen && !cfg_now && expected_replies.size() == 0)
				idle_run <= idle_run + 1;
			else
				idle_run <= 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$error("result strobe with no transaction outstanding");
				mismatches++;
			end else begin
				due = expected_replies.pop_front();
				if (status !== due.st) begin
					$error("status expected %0d actual %0d", due.st, status);
					mismatches++;
				end
				if (chunk_handle !== due.handle) begin
					$error("chunk_handle expected %0h actual %0h", due.handle, chunk_handle);
					mismatches++;
				end
				if (data_offset !== due.offset) begin
					$error("data_offset expected %0h actual %0h", due.offset, data_offset);
					mismatches++;
				end
				if (data_size !== due.nbytes) begin
					$error("data_size expected %0h actual %0h", due.nbytes, data_size);
					mismatches++;
				end
				if (live_chunks !== due.live) begin
					$error("live_chunks expected %0d actual %0d", due.live, live_chunks);
					mismatches++;
				end
			end
		end
	end

	function automatic int pick_gap();
		if (quiet_mode || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 13);
	endfunction

	// predictor state is current once nothing is queued or presented
	task automatic wait_slot();
		while (pending_requests.size() != 0 || start)
			@(negedge clk);
	endtask

	task automatic send_alloc(logic [31:0] nbytes, logic [4:0] alog);
		pool_req_t rq;
		wait_slot();
		rq.is_cfg = 1'b0;
		rq.reg_sel = REG_POOL_SIZE;
		rq.reg_val = '0;
		rq.kind = OP_ALLOC;
		rq.bytes = nbytes;
		rq.alog = alog;
		rq.handle = $urandom;
		rq.gap = pick_gap();
		pending_requests.push_back(rq);
	endtask

	task automatic send_free(logic [31:0] h);
		pool_req_t rq;
		wait_slot();
		rq.is_cfg = 1'b0;
		rq.reg_sel = REG_POOL_SIZE;
		rq.reg_val = '0;
		rq.kind = OP_FREE;
		rq.bytes = $urandom;
		rq.alog = $urandom_range(0, 31);
		rq.handle = h;
		rq.gap = pick_gap();
		pending_requests.push_back(rq);
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		pool_req_t rq;
		wait_slot();
		rq.is_cfg = 1'b1;
		rq.reg_sel = r;
		rq.reg_val = v;
		rq.kind = OP_ALLOC;
		rq.bytes = '0;
		rq.alog = '0;
		rq.handle = '0;
		rq.gap = 0;
		pending_requests.push_back(rq);
	endtask

	function automatic logic [31:0] pick_size();
		int unsigned span;
		int          idx;
		span = pool_bytes >> $urandom_range(3, 8);
		idx = $urandom_range(0, entry_total - 1);
		case ($urandom_range(0, 19))
			0: return '0;
			1: return $urandom;
			2: return chunk_size[idx];
			default: return $urandom_range(0, span + 8);
		endcase
	endfunction

	function automatic logic [4:0] pick_align();
		case ($urandom_range(0, 9))
			0: return $urandom_range(17, 31);
			1, 2: return $urandom_range(7, 16);
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	// mostly handles of live chunks, used ones preferred
	function automatic logic [31:0] pick_handle();
		int idx;
		int tries;
		idx = $urandom_range(0, entry_total - 1);
		for (tries = 0; tries < 4 && !chunk_used[idx]; tries++)
			idx = $urandom_range(0, entry_total - 1);
		case ($urandom_range(0, 19))
			0, 1: return $urandom;
			2: return chunk_start[idx] + 32'd1;
			default: return chunk_start[idx];
		endcase
	endfunction

	function automatic logic [31:0] pick_pool();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'd1;
			1: v = 32'hFFFF_FFFF;
			2: v = $urandom_range(1, 4096);
			3: v = $urandom_range(4096, 1 << 20);
			4: v = $urandom;
			default: v = POOL_SIZE_RST;
		endcase
		return (v == 0) ? 32'd1 : v;
	endfunction

	function automatic logic [31:0] pick_split();
		logic [15:0] v;
		case ($urandom_range(0, 4))
			0: v = '0;
			1: v = 16'hFFFF;
			2, 3: v = $urandom_range(0, 255);
			default: v = $urandom_range(0, 65535);
		endcase
		// upper data bits are ignored by the block
		return {16'($urandom), v};
	endfunction

	initial begin
		int phase;
		int n;
		int sent;
		int alloc_pct;
		int w;
		load_register(REG_POOL_SIZE, POOL_SIZE_RST);
		load_register(REG_MIN_SPLIT, {16'd0, MIN_SPLIT_RST});
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero request splits off an empty chunk sharing its start with the rest
		send_alloc(32'd0, 5'd0);
		send_alloc(32'd100, 5'd0);
		// alignment above the limit behaves as 2^16
		send_alloc(32'd10, 5'd31);
		send_alloc(32'hFFFF_FFFF, 5'd16);
		// lowest entry wins on a shared start, then a second free of the same chunk
		send_free(32'd0);
		send_free(32'd0);
		send_free(32'd100);
		send_free(32'd12345);
		send_free(32'hFFFF_FFFF);
		write_reg(REG_POOL_SIZE, 32'hFFFF_FFFF);
		write_reg(REG_MIN_SPLIT, 32'hFFFF_0000);
		send_alloc(32'hFFFF_FFFF, 5'd0);
		send_alloc(32'd0, 5'd0);
		send_free(32'd0);
		send_alloc(32'd1, 5'd16);
		send_alloc(32'd0, 5'd5);
		send_free(32'd1);
		write_reg(REG_POOL_SIZE, 32'd1);
		write_reg(REG_MIN_SPLIT, 32'h0000_FFFF);
		send_alloc(32'd0, 5'd0);
		send_alloc(32'd0, 5'd0);
		send_free(32'd0);
		send_alloc(32'd2, 5'd0);
		write_reg(REG_MIN_SPLIT, 32'h5A5A_0000);
		send_alloc(32'd0, 5'd3);
		send_free(32'd0);

		sent = 0;
		for (phase = 0; phase < PHASES; phase++) begin
			// first phase drives the table to its limit with tiny splits
			if (phase == 0) begin
				write_reg(REG_POOL_SIZE, 32'd4096);
				write_reg(REG_MIN_SPLIT, {16'($urandom), 16'd0});
				alloc_pct = 90;
			end else begin
				write_reg(REG_POOL_SIZE, pick_pool());
				write_reg(REG_MIN_SPLIT, pick_split());
				alloc_pct = $urandom_range(45, 80);
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (sent >= LATE_FROM)
					quiet_mode = 1'b1;
				else if ($urandom_range(0, 39) == 0)
					quiet_mode = !quiet_mode;
				// min_split alone leaves the table as it is
				if (n == ITEMS_PER_PHASE / 2 && $urandom_range(0, 1) == 1)
					write_reg(REG_MIN_SPLIT, pick_split());
				wait_slot();
				if ($urandom_range(1, 100) <= alloc_pct)
					send_alloc(pick_size(), pick_align());
				else
					send_free(pick_handle());
				sent++;
			end
		end

		wait_slot();
		for (w = 0; w < 5000 && expected_replies.size() != 0; w++)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (expected_replies.size() != 0)
			$error("%0d transactions never returned a result", expected_replies.size());
		if (mismatches == 0 && expected_replies.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
